// File: hw/rtl/g2sg_pkg.sv
`default_nettype none
package g2sg_pkg;

    // width of the angle fields on the ports
    localparam int ANGLE_BITS = 32;

    localparam int ITERS = 30;
    // datapath width of cordic x/y and width of the internal angle accumulator
    localparam int DW = 36;
    localparam int ZW = 34;

    localparam int SH_DN = (ANGLE_BITS >= 32) ? ANGLE_BITS - 32 : 0;
    localparam int SH_UP = (ANGLE_BITS < 32) ? 32 - ANGLE_BITS : 0;

    localparam logic signed [DW-1:0] CORDIC_K = 36'sd652032874;
    localparam logic signed [31:0]   CORDIC_G = 32'sd1768195363;
    localparam logic [31:0]          QUART32  = 32'h4000_0000;
    localparam logic [31:0]          HALF32   = 32'h8000_0000;
    localparam logic signed [ZW-1:0] QUART_Z  = 34'sd1073741824;

    // arctangent of 2^-i in 2^32 units per turn
    localparam logic signed [ZW-1:0] ATAN_TAB [ITERS] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
        34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772,
        34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861,
        34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304,
        34'sd652, 34'sd326, 34'sd163, 34'sd81,
        34'sd41, 34'sd20, 34'sd10, 34'sd5,
        34'sd3, 34'sd1
    };

    // rotation matrix, q1.30, row-major; the first row's z term is zero
    localparam logic signed [31:0] ROT00 = -32'sd789997574;
    localparam logic signed [31:0] ROT01 =  32'sd727203780;
    localparam logic signed [31:0] ROT10 = -32'sd80051510;
    localparam logic signed [31:0] ROT11 = -32'sd86963930;
    localparam logic signed [31:0] ROT12 =  32'sd1067216255;
    localparam logic signed [31:0] ROT20 =  32'sd722784265;
    localparam logic signed [31:0] ROT21 =  32'sd785196435;
    localparam logic signed [31:0] ROT22 =  32'sd118198855;

    typedef struct packed {
        logic [ANGLE_BITS-1:0]        gal_longitude;
        logic signed [ANGLE_BITS-1:0] gal_latitude;
    } request_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0]        sg_longitude;
        logic signed [ANGLE_BITS-1:0] sg_latitude;
    } result_t;

    // q.30 product back to q.30, round half up
    function automatic logic signed [63:0] rnd30(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p + 64'sd536870912;
        return s >>> 30;
    endfunction

    // port angle to 2^32 units per turn
    function automatic logic [31:0] to_internal(input logic [ANGLE_BITS-1:0] a);
        logic [ANGLE_BITS+31:0] w;
        w = {32'b0, a};
        w = (w >> SH_DN) << SH_UP;
        return w[31:0];
    endfunction

    // internal angle back to port width, floor for negative values
    function automatic logic [ANGLE_BITS-1:0] to_field(input logic signed [63:0] a);
        logic signed [63:0] w;
        w = (a <<< SH_DN) >>> SH_UP;
        return w[ANGLE_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/g2sg_cordic_rot.sv
`default_nettype none
// two-lane rotation cordic, one iteration per stage, x starts at the reciprocal of the cordic gain
module g2sg_cordic_rot #(
    parameter int SB_W = 2
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              load,
    input  wire logic signed [g2sg_pkg::ZW-1:0]    angle [2],
    input  wire logic [SB_W-1:0]                   flags,
    output logic                                   valid,
    output logic signed [g2sg_pkg::DW-1:0]         cosine [2],
    output logic signed [g2sg_pkg::DW-1:0]         sine [2],
    output logic [SB_W-1:0]                        flags_d
);

    localparam int N = g2sg_pkg::ITERS;

    logic                           v_s  [0:N];
    logic [SB_W-1:0]                sb_s [0:N];
    logic signed [g2sg_pkg::DW-1:0] x_s  [0:N][2];
    logic signed [g2sg_pkg::DW-1:0] y_s  [0:N][2];
    logic signed [g2sg_pkg::ZW-1:0] z_s  [0:N][2];

    assign v_s[0]  = load;
    assign sb_s[0] = flags;

    for (genvar l = 0; l < 2; l++) begin : g_in
        assign x_s[0][l] = g2sg_pkg::CORDIC_K;
        assign y_s[0][l] = '0;
        assign z_s[0][l] = angle[l];
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic                           v_reg;
        logic [SB_W-1:0]                sb_reg;
        logic signed [g2sg_pkg::DW-1:0] x_reg [2];
        logic signed [g2sg_pkg::DW-1:0] y_reg [2];
        logic signed [g2sg_pkg::ZW-1:0] z_reg [2];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else
            begin
                v_reg <= v_s[i];
            end
        end

        always_ff @(posedge clk)
        begin
            sb_reg <= sb_s[i];
            for (int l = 0; l < 2; l++)
            begin
                if (z_s[i][l] >= 0)
                begin
                    x_reg[l] <= x_s[i][l] - (y_s[i][l] >>> i);
                    y_reg[l] <= y_s[i][l] + (x_s[i][l] >>> i);
                    z_reg[l] <= z_s[i][l] - g2sg_pkg::ATAN_TAB[i];
                end
                else
                begin
                    x_reg[l] <= x_s[i][l] + (y_s[i][l] >>> i);
                    y_reg[l] <= y_s[i][l] - (x_s[i][l] >>> i);
                    z_reg[l] <= z_s[i][l] + g2sg_pkg::ATAN_TAB[i];
                end
            end
        end

        assign v_s[i+1]  = v_reg;
        assign sb_s[i+1] = sb_reg;
        for (genvar l = 0; l < 2; l++) begin : g_lane
            assign x_s[i+1][l] = x_reg[l];
            assign y_s[i+1][l] = y_reg[l];
            assign z_s[i+1][l] = z_reg[l];
        end
    end

    assign valid   = v_s[N];
    assign flags_d = sb_s[N];
    for (genvar l = 0; l < 2; l++) begin : g_out
        assign cosine[l] = x_s[N][l];
        assign sine[l]   = y_s[N][l];
    end

endmodule
`default_nettype wire

// File: hw/rtl/g2sg_cordic_vec.sv
`default_nettype none
// vectoring cordic for x >= 0, one iteration per stage; angle in 2^32 units per turn
module g2sg_cordic_vec #(
    parameter int SB_W = 1
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              load,
    input  wire logic signed [g2sg_pkg::DW-1:0]    x,
    input  wire logic signed [g2sg_pkg::DW-1:0]    y,
    input  wire logic [SB_W-1:0]                   flags,
    output logic                                   valid,
    output logic signed [g2sg_pkg::DW-1:0]         magnitude,
    output logic signed [g2sg_pkg::ZW-1:0]         angle,
    output logic [SB_W-1:0]                        flags_d
);

    localparam int N = g2sg_pkg::ITERS;

    logic                           v_s  [0:N];
    logic [SB_W-1:0]                sb_s [0:N];
    logic signed [g2sg_pkg::DW-1:0] x_s  [0:N];
    logic signed [g2sg_pkg::DW-1:0] y_s  [0:N];
    logic signed [g2sg_pkg::ZW-1:0] z_s  [0:N];

    assign v_s[0]  = load;
    assign sb_s[0] = flags;
    assign x_s[0]  = x;
    assign y_s[0]  = y;
    assign z_s[0]  = '0;

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic                           v_reg;
        logic [SB_W-1:0]                sb_reg;
        logic signed [g2sg_pkg::DW-1:0] x_reg;
        logic signed [g2sg_pkg::DW-1:0] y_reg;
        logic signed [g2sg_pkg::ZW-1:0] z_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else
            begin
                v_reg <= v_s[i];
            end
        end

        always_ff @(posedge clk)
        begin
            sb_reg <= sb_s[i];
            if (y_s[i] > 0)
            begin
                x_reg <= x_s[i] + (y_s[i] >>> i);
                y_reg <= y_s[i] - (x_s[i] >>> i);
                z_reg <= z_s[i] + g2sg_pkg::ATAN_TAB[i];
            end
            else
            begin
                x_reg <= x_s[i] - (y_s[i] >>> i);
                y_reg <= y_s[i] + (x_s[i] >>> i);
                z_reg <= z_s[i] - g2sg_pkg::ATAN_TAB[i];
            end
        end

        assign v_s[i+1]  = v_reg;
        assign sb_s[i+1] = sb_reg;
        assign x_s[i+1]  = x_reg;
        assign y_s[i+1]  = y_reg;
        assign z_s[i+1]  = z_reg;
    end

    assign valid     = v_s[N];
    assign flags_d   = sb_s[N];
    assign magnitude = x_s[N];
    assign angle     = z_s[N];

endmodule
`default_nettype wire

// File: hw/rtl/galactic_to_supergalactic.sv
// throughput: one request per cycle; busy is held low, the pipeline never stalls
// the pipeline is made of the three 30-stage cordic pipelines plus ten datapath registers
// reset: rst_n clears every valid bit at once; payload registers are not reset
// the receiver cannot stall: each result is shown for one cycle with done high
`default_nettype none
module galactic_to_supergalactic (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire g2sg_pkg::request_t request,
    output logic                    done,
    output g2sg_pkg::result_t       result
);

    localparam int DW = g2sg_pkg::DW;
    localparam int ZW = g2sg_pkg::ZW;
    localparam int LATENCY = 3 * g2sg_pkg::ITERS + 10;

    // never back-pressures: a request enters every cycle if offered
    assign busy = 1'b0;

    // ---------------------------------------------------------------
    // input stage: rescale both angles and fold into plus/minus quarter turn
    // ---------------------------------------------------------------
    logic [31:0]          lon_int;
    logic [31:0]          lat_int;
    logic [31:0]          lon_fold;
    logic [31:0]          lat_fold;
    logic [31:0]          lon_tst;
    logic [31:0]          lat_tst;
    logic                 a_valid_reg;
    logic signed [ZW-1:0] a_angle_reg [2];
    logic [1:0]           a_neg_reg;

    always_comb
    begin
        lon_int  = g2sg_pkg::to_internal(request.gal_longitude);
        lat_int  = g2sg_pkg::to_internal(request.gal_latitude);
        lon_tst  = lon_int + g2sg_pkg::QUART32;
        lat_tst  = lat_int + g2sg_pkg::QUART32;
        // second or third quadrant: turn by half a turn and negate the results later
        lon_fold = lon_tst[31] ? lon_int + g2sg_pkg::HALF32 : lon_int;
        lat_fold = lat_tst[31] ? lat_int + g2sg_pkg::HALF32 : lat_int;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        a_angle_reg[0] <= ZW'(signed'(lon_fold));
        a_angle_reg[1] <= ZW'(signed'(lat_fold));
        a_neg_reg      <= {lat_tst[31], lon_tst[31]};
    end

    // ---------------------------------------------------------------
    // cosine and sine of longitude (lane 0) and latitude (lane 1)
    // ---------------------------------------------------------------
    logic                 r_valid;
    logic signed [DW-1:0] r_cos [2];
    logic signed [DW-1:0] r_sin [2];
    logic [1:0]           r_neg;

    g2sg_cordic_rot #(
        .SB_W (2)
    ) u_rot (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (a_valid_reg),
        .angle   (a_angle_reg),
        .flags   (a_neg_reg),
        .valid   (r_valid),
        .cosine  (r_cos),
        .sine    (r_sin),
        .flags_d (r_neg)
    );

    // ---------------------------------------------------------------
    // quadrant fix-up, then the unit vector and the matrix product
    // ---------------------------------------------------------------
    logic                 b_valid_reg;
    logic signed [31:0]   cl_reg;
    logic signed [31:0]   sl_reg;
    logic signed [31:0]   cb_reg;
    logic signed [31:0]   sb_reg;

    logic                 c_valid_reg;
    logic signed [63:0]   p0_reg;
    logic signed [63:0]   p1_reg;
    logic signed [31:0]   c_sb_reg;

    logic                 d_valid_reg;
    logic signed [31:0]   v1_reg [3];

    logic                 e_valid_reg;
    logic signed [63:0]   m_reg [8];

    logic                 f_valid_reg;
    logic signed [ZW-1:0] v2_reg [3];

    logic signed [DW-1:0] cl_next;
    logic signed [DW-1:0] sl_next;
    logic signed [DW-1:0] cb_next;
    logic signed [DW-1:0] sb_next;
    logic signed [63:0]   row0_next;
    logic signed [63:0]   row1_next;
    logic signed [63:0]   row2_next;

    always_comb
    begin
        cl_next   = r_neg[0] ? -r_cos[0] : r_cos[0];
        sl_next   = r_neg[0] ? -r_sin[0] : r_sin[0];
        cb_next   = r_neg[1] ? -r_cos[1] : r_cos[1];
        sb_next   = r_neg[1] ? -r_sin[1] : r_sin[1];
        row0_next = g2sg_pkg::rnd30(m_reg[0] + m_reg[1]);
        row1_next = g2sg_pkg::rnd30(m_reg[2] + m_reg[3] + m_reg[4]);
        row2_next = g2sg_pkg::rnd30(m_reg[5] + m_reg[6] + m_reg[7]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= r_valid;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // sines and cosines stay within about one in q.30
        cl_reg    <= cl_next[31:0];
        sl_reg    <= sl_next[31:0];
        cb_reg    <= cb_next[31:0];
        sb_reg    <= sb_next[31:0];

        p0_reg    <= 64'(cb_reg) * 64'(cl_reg);
        p1_reg    <= 64'(cb_reg) * 64'(sl_reg);
        c_sb_reg  <= sb_reg;

        v1_reg[0] <= 32'(g2sg_pkg::rnd30(p0_reg));
        v1_reg[1] <= 32'(g2sg_pkg::rnd30(p1_reg));
        v1_reg[2] <= c_sb_reg;

        m_reg[0]  <= 64'(g2sg_pkg::ROT00) * 64'(v1_reg[0]);
        m_reg[1]  <= 64'(g2sg_pkg::ROT01) * 64'(v1_reg[1]);
        m_reg[2]  <= 64'(g2sg_pkg::ROT10) * 64'(v1_reg[0]);
        m_reg[3]  <= 64'(g2sg_pkg::ROT11) * 64'(v1_reg[1]);
        m_reg[4]  <= 64'(g2sg_pkg::ROT12) * 64'(v1_reg[2]);
        m_reg[5]  <= 64'(g2sg_pkg::ROT20) * 64'(v1_reg[0]);
        m_reg[6]  <= 64'(g2sg_pkg::ROT21) * 64'(v1_reg[1]);
        m_reg[7]  <= 64'(g2sg_pkg::ROT22) * 64'(v1_reg[2]);

        v2_reg[0] <= ZW'(row0_next);
        v2_reg[1] <= ZW'(row1_next);
        v2_reg[2] <= ZW'(row2_next);
    end

    // ---------------------------------------------------------------
    // atan2 set-up: pole check, fold into right half plane, scale z by the gain
    // ---------------------------------------------------------------
    logic                 g_valid_reg;
    logic                 g_pole_reg;
    logic                 g_base_reg;
    logic signed [DW-1:0] g_x_reg;
    logic signed [DW-1:0] g_y_reg;
    logic signed [63:0]   g_zp_reg;

    logic                 h_valid_reg;
    logic                 h_pole_reg;
    logic                 h_base_reg;
    logic signed [DW-1:0] h_x_reg;
    logic signed [DW-1:0] h_y_reg;
    logic signed [DW-1:0] h_zs_reg;

    logic signed [DW-1:0] v2x_ext;
    logic signed [DW-1:0] v2y_ext;
    logic                 left_half;

    always_comb
    begin
        v2x_ext   = DW'(v2_reg[0]);
        v2y_ext   = DW'(v2_reg[1]);
        left_half = v2_reg[0] < 0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
        end
        else
        begin
            g_valid_reg <= f_valid_reg;
            h_valid_reg <= g_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        g_pole_reg <= (v2_reg[0] == '0) && (v2_reg[1] == '0);
        g_base_reg <= left_half;
        g_x_reg    <= left_half ? -v2x_ext : v2x_ext;
        g_y_reg    <= left_half ? -v2y_ext : v2y_ext;
        g_zp_reg   <= 64'(v2_reg[2]) * 64'(g2sg_pkg::CORDIC_G);

        h_pole_reg <= g_pole_reg;
        h_base_reg <= g_base_reg;
        h_x_reg    <= g_x_reg;
        h_y_reg    <= g_y_reg;
        h_zs_reg   <= DW'(g2sg_pkg::rnd30(g_zp_reg));
    end

    // ---------------------------------------------------------------
    // first atan2: longitude, and the equatorial magnitude times the gain
    // ---------------------------------------------------------------
    localparam int SB1_W = 2 + DW;

    logic                 s1_valid;
    logic signed [DW-1:0] s1_mag;
    logic signed [ZW-1:0] s1_ang;
    logic [SB1_W-1:0]     s1_flags;

    g2sg_cordic_vec #(
        .SB_W (SB1_W)
    ) u_vec_lon (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (h_valid_reg),
        .x         (h_x_reg),
        .y         (h_y_reg),
        .flags     ({h_pole_reg, h_base_reg, h_zs_reg}),
        .valid     (s1_valid),
        .magnitude (s1_mag),
        .angle     (s1_ang),
        .flags_d   (s1_flags)
    );

    logic                 i_valid_reg;
    logic                 i_zero_reg;
    logic [31:0]          i_lon_reg;
    logic signed [DW-1:0] i_x_reg;
    logic signed [DW-1:0] i_y_reg;

    logic                 s1_pole;
    logic                 s1_base;
    logic signed [DW-1:0] s1_zs;
    logic [31:0]          lon_next;

    always_comb
    begin
        s1_pole  = s1_flags[SB1_W-1];
        s1_base  = s1_flags[SB1_W-2];
        s1_zs    = s1_flags[DW-1:0];
        // pole gives longitude zero; otherwise wrap modulo a turn
        if (s1_pole)
        begin
            lon_next = '0;
        end
        else
        begin
            lon_next = s1_ang[31:0] + (s1_base ? g2sg_pkg::HALF32 : 32'h0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_valid_reg <= 1'b0;
        end
        else
        begin
            i_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        i_lon_reg  <= lon_next;
        i_zero_reg <= (s1_mag == '0) && (s1_zs == '0);
        i_x_reg    <= s1_mag;
        i_y_reg    <= s1_zs;
    end

    // ---------------------------------------------------------------
    // second atan2: latitude from magnitude and scaled z
    // ---------------------------------------------------------------
    localparam int SB2_W = 33;

    logic                 s2_valid;
    logic signed [DW-1:0] s2_mag;
    logic signed [ZW-1:0] s2_ang;
    logic [SB2_W-1:0]     s2_flags;

    g2sg_cordic_vec #(
        .SB_W (SB2_W)
    ) u_vec_lat (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (i_valid_reg),
        .x         (i_x_reg),
        .y         (i_y_reg),
        .flags     ({i_zero_reg, i_lon_reg}),
        .valid     (s2_valid),
        .magnitude (s2_mag),
        .angle     (s2_ang),
        .flags_d   (s2_flags)
    );

    // ---------------------------------------------------------------
    // output register: clamp latitude, rescale both angles to port width
    // ---------------------------------------------------------------
    logic                 done_reg;
    g2sg_pkg::result_t    result_reg;
    logic signed [ZW-1:0] lat_next;

    always_comb
    begin
        // zero vector gives latitude zero; overshoot clamps to the pole
        if (s2_flags[SB2_W-1])
        begin
            lat_next = '0;
        end
        else if (s2_ang > g2sg_pkg::QUART_Z)
        begin
            lat_next = g2sg_pkg::QUART_Z;
        end
        else if (s2_ang < -g2sg_pkg::QUART_Z)
        begin
            lat_next = -g2sg_pkg::QUART_Z;
        end
        else
        begin
            lat_next = s2_ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.sg_longitude <= g2sg_pkg::to_field(64'(s2_flags[31:0]));
        result_reg.sg_latitude  <= g2sg_pkg::to_field(64'(lat_next));
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTH
    // a result only ever comes from a request taken earlier at the head of the pipeline
    a_done_from_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("done without a matching request");

    // clamped latitude stays within a quarter turn
    a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid |-> (lat_next <= g2sg_pkg::QUART_Z) && (lat_next >= -g2sg_pkg::QUART_Z))
        else $error("latitude outside quarter turn");

    // second atan2 starts with x >= 0 so its magnitude never goes negative
    a_mag_sign: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid |-> !s2_mag[DW-1])
        else $error("negative magnitude in latitude cordic");

    // a pole always maps to longitude zero
    a_pole_lon: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid && s1_pole) |=> (i_lon_reg == '0))
        else $error("pole longitude not zero");
`endif

endmodule
`default_nettype wire
